// ===== sv/circle_circle_intersection_top_macros.svh =====
// ----------------------------------------------------------------------------
// Circle intersection assertion macros
// Shared assertion forms used by the circle intersection top level.
// ----------------------------------------------------------------------------
`ifndef CIRCLE_CIRCLE_INTERSECTION_TOP_MACROS_SVH
`define CIRCLE_CIRCLE_INTERSECTION_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk and idle during reset.
`define CCI_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and idle during reset.
`define CCI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/cci_pkg.sv =====
// ----------------------------------------------------------------------------
// Circle intersection package
// Shared constants and the meeting status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package cci_pkg;

	localparam int COORD_BITS_DEF = 32;
	localparam int TOL_W = 16;
	localparam logic [TOL_W-1:0] TOL_RESET = 16'd1;

	typedef enum logic [1:0] {
		MEET_NONE  = 2'd0,
		MEET_ONE   = 2'd1,
		MEET_TWO   = 2'd2,
		MEET_COINC = 2'd3
	} meet_t;

endpackage

`default_nettype wire

// ===== sv/cci_ifs.sv =====
// ----------------------------------------------------------------------------
// Circle intersection channels
// Valid/ready channels for circle pairs, results and the tolerance write.
// ----------------------------------------------------------------------------
`default_nettype none

interface cci_in_if #(
	parameter int CB = cci_pkg::COORD_BITS_DEF
) ();
	logic                 valid;
	logic                 ready;
	logic signed [CB-1:0] first_centre_x;
	logic signed [CB-1:0] first_centre_y;
	logic        [CB-2:0] first_radius;
	logic signed [CB-1:0] second_centre_x;
	logic signed [CB-1:0] second_centre_y;
	logic        [CB-2:0] second_radius;

	modport source (
		output valid, first_centre_x, first_centre_y, first_radius,
		output second_centre_x, second_centre_y, second_radius,
		input  ready
	);
	modport sink (
		input  valid, first_centre_x, first_centre_y, first_radius,
		input  second_centre_x, second_centre_y, second_radius,
		output ready
	);
endinterface

interface cci_out_if #(
	parameter int CB = cci_pkg::COORD_BITS_DEF
) ();
	logic                 valid;
	logic                 ready;
	logic        [1:0]    meet_status;
	logic signed [CB-1:0] first_x;
	logic signed [CB-1:0] first_y;
	logic signed [CB-1:0] second_x;
	logic signed [CB-1:0] second_y;

	modport source (
		output valid, meet_status, first_x, first_y, second_x, second_y,
		input  ready
	);
	modport sink (
		input  valid, meet_status, first_x, first_y, second_x, second_y,
		output ready
	);
endinterface

interface cci_cfg_if ();
	logic                       valid;
	logic                       ready;
	logic [cci_pkg::TOL_W-1:0] tolerance;

	modport source (output valid, tolerance, input ready);
	modport sink (input valid, tolerance, output ready);
endinterface

`default_nettype wire

// ===== sv/circle_circle_intersection_top.sv =====
// Circle pair intersection in signed Q16.16. One circle pair is taken per clock while the
// pipeline is not stalled, and results leave in order, one result per pair. Three bit-per-stage
// pipelines run in series (distance square root, chord foot divider, half chord square root),
// followed by the four-lane point divider. A stalled result output holds the whole pipeline
// only once its last stage is full; the tolerance register is written with no wait.
// ----------------------------------------------------------------------------
// Circle intersection top level
// Front end, wide multiplies and point assembly around the pipelined units.
// ----------------------------------------------------------------------------
`default_nettype none

`include "circle_circle_intersection_top_macros.svh"

module circle_circle_intersection_top #(
	parameter int COORD_BITS = cci_pkg::COORD_BITS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	cci_in_if.sink    circles,
	cci_out_if.source meet,
	cci_cfg_if.sink   cfg
);

	localparam int C   = COORD_BITS;
	localparam int CW1 = C + 1;
	localparam int CW3 = C + 3;
	localparam int CW4 = C + 4;
	localparam int W0  = 2 * C;
	localparam int W2  = 2 * C + 2;
	localparam int WR  = 2 * C - 2;

	localparam logic signed [CW4-1:0] SMAX = {{5{1'b0}}, {(C-1){1'b1}}};
	localparam logic signed [CW4-1:0] SMIN = {{5{1'b1}}, {(C-1){1'b0}}};

	typedef struct packed {
		logic signed [C-1:0] x0;
		logic signed [C-1:0] y0;
		logic signed [C:0]   dx;
		logic signed [C:0]   dy;
		logic [C-2:0]        r0;
		logic [C-2:0]        r1;
		logic [C-1:0]        rr;
		logic [C-2:0]        rd;
		logic                rej;
	} side1_t;

	typedef struct packed {
		logic signed [C-1:0] x0;
		logic signed [C-1:0] y0;
		logic signed [C:0]   dx;
		logic signed [C:0]   dy;
		logic [C:0]          len;
		logic [C-2:0]        r0;
		cci_pkg::meet_t      status;
		logic                aneg;
	} side2_t;

	typedef struct packed {
		logic signed [C-1:0] x0;
		logic signed [C-1:0] y0;
		logic signed [C:0]   dx;
		logic signed [C:0]   dy;
		logic [C:0]          len;
		logic [C:0]          amag;
		logic                aneg;
		cci_pkg::meet_t      status;
	} side3_t;

	typedef struct packed {
		logic signed [C-1:0] x0;
		logic signed [C-1:0] y0;
		logic                sdx;
		logic                sdy;
		logic                aneg;
		cci_pkg::meet_t      status;
	} side4_t;

	function automatic logic [C:0] mag_f(input logic signed [C:0] v);
		logic [C:0] u;
		u = v;
		return v[C] ? (~u + 1'b1) : u;
	endfunction

	function automatic logic [CW3-1:0] absd_f(input logic [CW3-1:0] a, input logic [CW3-1:0] b);
		return (a >= b) ? (a - b) : (b - a);
	endfunction

	function automatic logic [C-1:0] sat_f(input logic signed [CW4-1:0] v);
		logic signed [CW4-1:0] t;
		t = v;
		if (v > SMAX) begin
			t = SMAX;
		end else if (v < SMIN) begin
			t = SMIN;
		end
		return t[C-1:0];
	endfunction

	logic                   en;
	logic [cci_pkg::TOL_W-1:0] tol_q;

	logic                   v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;
	logic                   out_v_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= cci_pkg::TOL_RESET;
		end else if (cfg.valid) begin
			tol_q <= cfg.tolerance;
		end
	end

	// The pipeline moves as one; it stops only when the output register is full and stalled
	// and the last stage holds an item.
	assign en            = !(v_s10 && out_v_q && !meet.ready);
	assign circles.ready = en;

	// Stage 1: differences and radius sum and difference.
	logic signed [C-1:0] x0_s1, y0_s1;
	logic signed [C:0]   dx_s1, dy_s1;
	logic [C-2:0]        r0_s1, r1_s1, rd_s1;
	logic [C-1:0]        rr_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			x0_s1 <= circles.first_centre_x;
			y0_s1 <= circles.first_centre_y;
			dx_s1 <= CW1'(circles.second_centre_x) - CW1'(circles.first_centre_x);
			dy_s1 <= CW1'(circles.second_centre_y) - CW1'(circles.first_centre_y);
			r0_s1 <= circles.first_radius;
			r1_s1 <= circles.second_radius;
			rr_s1 <= C'(circles.first_radius) + C'(circles.second_radius);
			rd_s1 <= (circles.first_radius >= circles.second_radius) ?
				(circles.first_radius - circles.second_radius) :
				(circles.second_radius - circles.first_radius);
		end
	end

	// Stage 2: squares.
	logic [C:0]    mdx1, mdy1;
	logic [W2-1:0] dxsq_s2, dysq_s2;
	logic [W0-1:0] rrsq_s2;
	logic [WR-1:0] rdsq_s2;
	side1_t        sd_s2;

	assign mdx1 = mag_f(dx_s1);
	assign mdy1 = mag_f(dy_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			dxsq_s2 <= W2'(mdx1) * W2'(mdx1);
			dysq_s2 <= W2'(mdy1) * W2'(mdy1);
			rrsq_s2 <= W0'(rr_s1) * W0'(rr_s1);
			rdsq_s2 <= WR'(rd_s1) * WR'(rd_s1);
			sd_s2   <= '{x0: x0_s1, y0: y0_s1, dx: dx_s1, dy: dy_s1, r0: r0_s1, r1: r1_s1,
				rr: rr_s1, rd: rd_s1, rej: 1'b0};
		end
	end

	// Stage 3: squared distance and the cases with no meeting.
	logic [W2-1:0] d2, d2_s3;
	side1_t        sd3_n, sd_s3;

	assign d2 = dxsq_s2 + dysq_s2;

	always_comb begin
		sd3_n     = sd_s2;
		sd3_n.rej = (d2 == '0) || (d2 > W2'(rrsq_s2)) || (d2 < W2'(rdsq_s2));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d2_s3 <= d2;
			sd_s3 <= sd3_n;
		end
	end

	logic       v_l;
	logic [C:0] len_l;
	side1_t     sd_l;

	cci_isqrt #(
		.NW (W2),
		.SW ($bits(side1_t))
	) u_len_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_v     (v_s3),
		.rad      (d2_s3),
		.side_in  (sd_s3),
		.out_v    (v_l),
		.root     (len_l),
		.side_out (sd_l)
	);

	// Stage 4: status and the squares for the chord foot.
	logic           coinc, tang;
	cci_pkg::meet_t st4;
	logic [W2-1:0]  lensq_s4;
	logic [WR-1:0]  r0sq_s4, r1sq_s4;
	side2_t         sd_s4;

	assign coinc = (len_l < CW1'(tol_q)) && (CW1'(sd_l.rd) < CW1'(tol_q));
	assign tang  = (absd_f(CW3'(sd_l.rr), CW3'(len_l)) < CW3'(tol_q)) ||
		(absd_f(CW3'(len_l), CW3'(sd_l.rd)) < CW3'(tol_q));

	always_comb begin
		if (coinc) begin
			st4 = cci_pkg::MEET_COINC;
		end else if (sd_l.rej) begin
			st4 = cci_pkg::MEET_NONE;
		end else if (tang) begin
			st4 = cci_pkg::MEET_ONE;
		end else begin
			st4 = cci_pkg::MEET_TWO;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lensq_s4 <= W2'(len_l) * W2'(len_l);
			r0sq_s4  <= WR'(sd_l.r0) * WR'(sd_l.r0);
			r1sq_s4  <= WR'(sd_l.r1) * WR'(sd_l.r1);
			sd_s4    <= '{x0: sd_l.x0, y0: sd_l.y0, dx: sd_l.dx, dy: sd_l.dy, len: len_l,
				r0: sd_l.r0, status: st4, aneg: 1'b0};
		end
	end

	// Stage 5 and 6: numerator of the chord foot and its sign.
	logic [W2-1:0] p_s5, n_s6;
	logic [WR-1:0] r1sq_s5;
	side2_t        sd_s5, sd_s6, sd6_n;
	logic          aneg6;

	assign aneg6 = p_s5 < W2'(r1sq_s5);

	always_comb begin
		sd6_n      = sd_s5;
		sd6_n.aneg = aneg6;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s5        <= lensq_s4 + W2'(r0sq_s4);
			r1sq_s5     <= r1sq_s4;
			sd_s5       <= sd_s4;
			n_s6        <= aneg6 ? (W2'(r1sq_s5) - p_s5) : (p_s5 - W2'(r1sq_s5));
			sd_s6       <= sd6_n;
		end
	end

	logic            v_a;
	logic [0:0][C:0] amag_a;
	side2_t          sd_a;

	cci_div #(
		.NW (W2),
		.DW (C + 2),
		.QW (CW1),
		.LN (1),
		.SW ($bits(side2_t))
	) u_foot_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_v     (v_s6),
		.num      (n_s6),
		.den      ({sd_s6.len, 1'b0}),
		.side_in  (sd_s6),
		.out_v    (v_a),
		.quo      (amag_a),
		.side_out (sd_a)
	);

	// Stage 7 and 8: radicand of the half chord.
	logic [W2-1:0] asq_s7;
	logic [WR-1:0] r0sq_s7, hrad_s8;
	side3_t        sd_s7, sd_s8;

	always_ff @(posedge clk) begin
		if (en) begin
			asq_s7  <= W2'(amag_a[0]) * W2'(amag_a[0]);
			r0sq_s7 <= WR'(sd_a.r0) * WR'(sd_a.r0);
			sd_s7   <= '{x0: sd_a.x0, y0: sd_a.y0, dx: sd_a.dx, dy: sd_a.dy, len: sd_a.len,
				amag: amag_a[0], aneg: sd_a.aneg, status: sd_a.status};
			hrad_s8 <= (asq_s7 >= W2'(r0sq_s7)) ? '0 : (r0sq_s7 - asq_s7[WR-1:0]);
			sd_s8   <= sd_s7;
		end
	end

	logic         v_h;
	logic [C-2:0] h_h;
	side3_t       sd_h;

	cci_isqrt #(
		.NW (WR),
		.SW ($bits(side3_t))
	) u_half_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_v     (v_s8),
		.rad      (hrad_s8),
		.side_in  (sd_s8),
		.out_v    (v_h),
		.root     (h_h),
		.side_out (sd_h)
	);

	// Stage 9: offset products; lanes are a*dx, a*dy, h*dx, h*dy.
	logic [C:0]          mdx9, mdy9;
	logic [3:0][W2-1:0]  num_s9;
	logic [C:0]          len_s9;
	side4_t              sd_s9;

	assign mdx9 = mag_f(sd_h.dx);
	assign mdy9 = mag_f(sd_h.dy);

	always_ff @(posedge clk) begin
		if (en) begin
			num_s9[0] <= W2'(sd_h.amag) * W2'(mdx9);
			num_s9[1] <= W2'(sd_h.amag) * W2'(mdy9);
			num_s9[2] <= W2'(h_h) * W2'(mdx9);
			num_s9[3] <= W2'(h_h) * W2'(mdy9);
			len_s9    <= sd_h.len;
			sd_s9     <= '{x0: sd_h.x0, y0: sd_h.y0, sdx: sd_h.dx[C], sdy: sd_h.dy[C],
				aneg: sd_h.aneg, status: sd_h.status};
		end
	end

	logic            v_p;
	logic [3:0][C:0] q_p;
	side4_t          sd_p;

	cci_div #(
		.NW (W2),
		.DW (CW1),
		.QW (CW1),
		.LN (4),
		.SW ($bits(side4_t))
	) u_point_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_v     (v_s9),
		.num      (num_s9),
		.den      (len_s9),
		.side_in  (sd_s9),
		.out_v    (v_p),
		.quo      (q_p),
		.side_out (sd_p)
	);

	// Stage 10: signed offsets and the chord foot point.
	logic signed [CW3-1:0] qax, qay, qhx, qhy;
	logic signed [CW3-1:0] bx_s10, by_s10, hx_s10, hy_s10;
	cci_pkg::meet_t        st_s10;

	assign qax = signed'(CW3'(q_p[0]));
	assign qay = signed'(CW3'(q_p[1]));
	assign qhx = signed'(CW3'(q_p[2]));
	assign qhy = signed'(CW3'(q_p[3]));

	always_ff @(posedge clk) begin
		if (en) begin
			bx_s10 <= CW3'(sd_p.x0) + ((sd_p.aneg != sd_p.sdx) ? -qax : qax);
			by_s10 <= CW3'(sd_p.y0) + ((sd_p.aneg != sd_p.sdy) ? -qay : qay);
			hx_s10 <= sd_p.sdx ? -qhx : qhx;
			hy_s10 <= sd_p.sdy ? -qhy : qhy;
			st_s10 <= sd_p.status;
		end
	end

	// Output register: the two points, saturated, with unused points cleared.
	logic [1:0]          status_q;
	logic signed [C-1:0] fx_q, fy_q, sx_q, sy_q;
	logic                has_first, has_second;

	assign has_first  = (st_s10 == cci_pkg::MEET_ONE) || (st_s10 == cci_pkg::MEET_TWO);
	assign has_second = (st_s10 == cci_pkg::MEET_TWO);

	always_ff @(posedge clk) begin
		if (!out_v_q || meet.ready) begin
			status_q <= st_s10;
			fx_q     <= has_first ? sat_f(CW4'(bx_s10) - CW4'(hy_s10)) : '0;
			fy_q     <= has_first ? sat_f(CW4'(by_s10) + CW4'(hx_s10)) : '0;
			sx_q     <= has_second ? sat_f(CW4'(bx_s10) + CW4'(hy_s10)) : '0;
			sy_q     <= has_second ? sat_f(CW4'(by_s10) - CW4'(hx_s10)) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			v_s5    <= 1'b0;
			v_s6    <= 1'b0;
			v_s7    <= 1'b0;
			v_s8    <= 1'b0;
			v_s9    <= 1'b0;
			v_s10   <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (en) begin
				v_s1  <= circles.valid;
				v_s2  <= v_s1;
				v_s3  <= v_s2;
				v_s4  <= v_l;
				v_s5  <= v_s4;
				v_s6  <= v_s5;
				v_s7  <= v_a;
				v_s8  <= v_s7;
				v_s9  <= v_h;
				v_s10 <= v_p;
			end
			if (!out_v_q || meet.ready) begin
				out_v_q <= v_s10;
			end
		end
	end

	assign meet.valid       = out_v_q;
	assign meet.meet_status = status_q;
	assign meet.first_x     = fx_q;
	assign meet.first_y     = fy_q;
	assign meet.second_x    = sx_q;
	assign meet.second_y    = sy_q;

	`CCI_ASSERT_NOW(a_no_point,
		meet.valid && (meet.meet_status == cci_pkg::MEET_NONE ||
		meet.meet_status == cci_pkg::MEET_COINC),
		meet.first_x == '0 && meet.first_y == '0, "point reported without a meeting")
	`CCI_ASSERT_NOW(a_no_second, meet.valid && meet.meet_status != cci_pkg::MEET_TWO,
		meet.second_x == '0 && meet.second_y == '0, "second point reported without two points")
	`CCI_ASSERT_NOW(a_full_stall, v_s10 && out_v_q && !meet.ready, !circles.ready,
		"input taken while the pipeline is blocked")
	`CCI_ASSERT_NEXT(a_tol_write, cfg.valid && cfg.ready, tol_q == $past(cfg.tolerance),
		"tolerance write lost")

endmodule

`default_nettype wire

// ===== sv/cci_isqrt.sv =====
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Floor square root, one root bit per register stage, with a sideband word.
// ----------------------------------------------------------------------------
`default_nettype none

module cci_isqrt #(
	parameter int NW = 66,
	parameter int SW = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_v,
	input  logic [NW-1:0]    rad,
	input  logic [SW-1:0]    side_in,
	output logic             out_v,
	output logic [NW/2-1:0]  root,
	output logic [SW-1:0]    side_out
);

	localparam int N = NW / 2;

	logic          v_s    [N];
	logic [N+1:0]  rem_s  [N];
	logic [N-1:0]  root_s [N];
	logic [NW-1:0] rad_s  [N];
	logic [SW-1:0] side_s [N];

	for (genvar k = 0; k < N; k++) begin : g_st
		logic          v_i;
		logic [N+1:0]  rem_i;
		logic [N-1:0]  root_i;
		logic [NW-1:0] rad_i;
		logic [SW-1:0] side_i;
		logic [N+3:0]  rem_x;
		logic [N+3:0]  trial;
		logic [N+3:0]  diff;
		logic          ge;

		if (k == 0) begin : g_first
			assign v_i    = in_v;
			assign rem_i  = '0;
			assign root_i = '0;
			assign rad_i  = rad;
			assign side_i = side_in;
		end else begin : g_next
			assign v_i    = v_s[k-1];
			assign rem_i  = rem_s[k-1];
			assign root_i = root_s[k-1];
			assign rad_i  = rad_s[k-1];
			assign side_i = side_s[k-1];
		end

		assign rem_x = {rem_i, rad_i[NW-1 -: 2]};
		assign trial = {2'b00, root_i, 2'b01};
		assign diff  = rem_x - trial;
		assign ge    = rem_x >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? diff[N+1:0] : rem_x[N+1:0];
				root_s[k] <= {root_i[N-2:0], ge};
				rad_s[k]  <= {rad_i[NW-3:0], 2'b00};
				side_s[k] <= side_i;
			end
		end
	end

	assign out_v    = v_s[N-1];
	assign root     = root_s[N-1];
	assign side_out = side_s[N-1];

endmodule

`default_nettype wire

// ===== sv/cci_div.sv =====
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One or more numerators (LN lanes) over one shared divisor, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module cci_div #(
	parameter int NW = 66,
	parameter int DW = 33,
	parameter int QW = 33,
	parameter int LN = 1,
	parameter int SW = 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_v,
	input  logic [LN-1:0][NW-1:0]  num,
	input  logic [DW-1:0]          den,
	input  logic [SW-1:0]          side_in,
	output logic                   out_v,
	output logic [LN-1:0][QW-1:0]  quo,
	output logic [SW-1:0]          side_out
);

	localparam int RW = (NW > DW + QW) ? NW : DW + QW;

	logic                  v_s    [QW];
	logic [LN-1:0][RW-1:0] rem_s  [QW];
	logic [LN-1:0][QW-1:0] quo_s  [QW];
	logic [DW-1:0]         den_s  [QW];
	logic [SW-1:0]         side_s [QW];

	for (genvar k = 0; k < QW; k++) begin : g_st
		logic                  v_i;
		logic [LN-1:0][RW-1:0] rem_i;
		logic [LN-1:0][RW-1:0] rem_n;
		logic [LN-1:0][QW-1:0] quo_i;
		logic [LN-1:0][QW-1:0] quo_n;
		logic [DW-1:0]         den_i;
		logic [SW-1:0]         side_i;
		logic [RW-1:0]         dsh;

		if (k == 0) begin : g_first
			assign v_i    = in_v;
			assign den_i  = den;
			assign side_i = side_in;
			assign quo_i  = '0;
			always_comb begin
				for (int l = 0; l < LN; l++) begin
					rem_i[l] = RW'(num[l]);
				end
			end
		end else begin : g_next
			assign v_i    = v_s[k-1];
			assign den_i  = den_s[k-1];
			assign side_i = side_s[k-1];
			assign quo_i  = quo_s[k-1];
			assign rem_i  = rem_s[k-1];
		end

		assign dsh = RW'(den_i) << (QW - 1 - k);

		always_comb begin
			for (int l = 0; l < LN; l++) begin
				if (rem_i[l] >= dsh) begin
					rem_n[l] = rem_i[l] - dsh;
					quo_n[l] = {quo_i[l][QW-2:0], 1'b1};
				end else begin
					rem_n[l] = rem_i[l];
					quo_n[l] = {quo_i[l][QW-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= rem_n;
				quo_s[k]  <= quo_n;
				den_s[k]  <= den_i;
				side_s[k] <= side_i;
			end
		end
	end

	assign out_v    = v_s[QW-1];
	assign quo      = quo_s[QW-1];
	assign side_out = side_s[QW-1];

endmodule

`default_nettype wire
